@@ sv/knn_top_k_list_macros.svh @@
// ----------------------------------------------------------------------------
// knn_top_k_list assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef KNN_TOP_K_LIST_MACROS_SVH
`define KNN_TOP_K_LIST_MACROS_SVH

`ifndef SYNTHESIS
`define KNN_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define KNN_ASSERT_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);
`else
`define KNN_ASSERT(lbl, ck, rn, prop, msg)
`define KNN_ASSERT_NEVER(lbl, ck, rn, expr, msg)
`endif

`endif

@@ sv/knn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants and types of the k nearest neighbor list
// ----------------------------------------------------------------------------
package knn_pkg;

	localparam int LIST_SIZE = 16;
	localparam int SLOT_W    = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
	localparam int CNT_W     = $clog2(LIST_SIZE + 1);
	localparam int ID_W      = 24;
	localparam int DIST_W    = 48;
	localparam int COORD_W   = 16;
	localparam int SQ_W      = 2 * (COORD_W + 1);
	localparam int KEY_W     = DIST_W + ID_W + SLOT_W;
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_COORD = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_OFFER,
		OP_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [ID_W-1:0]     id;
		logic [DIST_W-1:0]   dist_val;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WORST,
		BK_SCAN,
		BK_EMIT
	} bk_state_t;

endpackage

@@ sv/knn_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module knn_cmd_fifo
	import knn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head_cmd,
	output q_stat_t stat
);

	cmd_t                 entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wr_ptr_q;
	logic [CMDQ_AW-1:0]   rd_ptr_q;
	logic [CMDQ_AW:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign stat.full  = (count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ sv/knn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_front
// accepts items, squares coordinate differences and accumulates distances
// ----------------------------------------------------------------------------
module knn_front
	import knn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [1:0]          kind,
	input  logic [ID_W-1:0]     point_id,
	input  logic [COORD_W-1:0]  data_coord,
	input  logic [COORD_W-1:0]  query_coord,
	input  logic                last_coord,
	input  q_stat_t             q_stat,
	output logic                push,
	output cmd_t                push_cmd
);

	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [ID_W-1:0]      id_s1;
	logic [SQ_W-1:0]      sq_s1;
	logic                 last_s1;
	logic [DIST_W-1:0]    accum_q;

	logic signed [COORD_W:0]   diff;
	logic signed [SQ_W-1:0]    sq_full;
	logic [DIST_W:0]           sum_wide;
	logic [DIST_W-1:0]         sum_sat;
	logic                      needs_push;
	logic                      retire;

	assign diff    = $signed({data_coord[COORD_W-1], data_coord})
	               - $signed({query_coord[COORD_W-1], query_coord});
	assign sq_full = diff * diff;

	assign sum_wide = {1'b0, accum_q} + (DIST_W + 1)'(sq_s1);
	assign sum_sat  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];

	assign needs_push = valid_s1 && ((kind_s1 == KIND_CLEAR) || (kind_s1 == KIND_READ)
	                  || ((kind_s1 == KIND_COORD) && last_s1));
	assign push       = needs_push && !q_stat.full;
	assign retire     = valid_s1 && (!needs_push || !q_stat.full);
	assign s_axis_tready = !valid_s1 || retire;

	always_comb begin
		push_cmd.id       = id_s1;
		push_cmd.dist_val = sum_sat;
		unique case (kind_s1)
			KIND_CLEAR: push_cmd.op = OP_CLEAR;
			KIND_READ:  push_cmd.op = OP_READ;
			default:    push_cmd.op = OP_OFFER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			accum_q  <= '0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (retire) begin
				if (kind_s1 == KIND_CLEAR) accum_q <= '0;
				else if (kind_s1 == KIND_COORD) accum_q <= last_s1 ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= kind;
			id_s1   <= point_id;
			sq_s1   <= sq_full;
			last_s1 <= last_coord;
		end
	end

endmodule

@@ sv/knn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_back
// neighbor list: insert, worst-entry rescan and sorted readout
// ----------------------------------------------------------------------------
`include "knn_top_k_list_macros.svh"

module knn_back
	import knn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  q_stat_t            q_stat,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [ID_W-1:0]    nearest_id,
	output logic [DIST_W-1:0]  distance,
	output logic               valid_res,
	output logic               last
);

	logic [ID_W-1:0]    ids_q   [LIST_SIZE];
	logic [DIST_W-1:0]  dists_q [LIST_SIZE];

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [CNT_W-1:0]   fill_q;
	logic [DIST_W-1:0]  worst_dist_q;
	logic [SLOT_W-1:0]  worst_slot_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [CNT_W-1:0]   emit_cnt_q;
	logic               have_prev_q;
	logic               found_q;
	logic               out_valid_q;
	logic [KEY_W-1:0]   best_q;
	logic [KEY_W-1:0]   prev_q;

	logic               full;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_slot;
	logic [ID_W-1:0]    rd_id;
	logic [DIST_W-1:0]  rd_dist;
	logic [KEY_W-1:0]   cand;
	logic               take;
	logic               scan_end;
	logic               worst_end;
	logic               out_free;
	logic               emit_last;
	logic               emit;

	assign full      = (fill_q == CNT_W'(LIST_SIZE));
	assign wr_en     = pop && (cmd.op == OP_OFFER) && (!full || (cmd.dist_val < worst_dist_q));
	assign wr_slot   = full ? worst_slot_q : fill_q[SLOT_W-1:0];
	assign rd_id     = ids_q[idx_q];
	assign rd_dist   = dists_q[idx_q];
	assign cand      = {rd_dist, rd_id, idx_q};
	assign take      = (!have_prev_q || (cand > prev_q)) && (!found_q || (cand < best_q));
	assign scan_end  = (CNT_W'(idx_q) == fill_q - 1'b1);
	assign worst_end = (idx_q == SLOT_W'(LIST_SIZE - 1));
	assign out_free  = !out_valid_q || m_axis_tready;
	assign emit_last = (fill_q == '0) || (emit_cnt_q + 1'b1 == fill_q);
	assign emit      = (state_q == BK_EMIT) && out_free;
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					unique case (cmd.op)
						OP_OFFER: begin
							if (!full) begin
								if (fill_q == CNT_W'(LIST_SIZE - 1)) state_d = BK_WORST;
							end else if (cmd.dist_val < worst_dist_q) begin
								state_d = BK_WORST;
							end
						end
						OP_READ:  state_d = (fill_q == '0) ? BK_EMIT : BK_SCAN;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_WORST: begin
				if (worst_end) state_d = BK_IDLE;
			end
			BK_SCAN: begin
				if (scan_end) state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free) state_d = emit_last ? BK_IDLE : BK_SCAN;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			worst_dist_q <= '0;
			worst_slot_q <= '0;
			idx_q        <= '0;
			emit_cnt_q   <= '0;
			have_prev_q  <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					idx_q       <= '0;
					emit_cnt_q  <= '0;
					have_prev_q <= 1'b0;
					found_q     <= 1'b0;
					if (pop && (cmd.op == OP_CLEAR)) fill_q <= '0;
					if (wr_en && !full) fill_q <= fill_q + 1'b1;
				end
				BK_WORST: begin
					if ((idx_q == '0) || (rd_dist > worst_dist_q)) begin
						worst_dist_q <= rd_dist;
						worst_slot_q <= idx_q;
					end
					idx_q <= worst_end ? '0 : idx_q + 1'b1;
				end
				BK_SCAN: begin
					if (take) found_q <= 1'b1;
					idx_q <= scan_end ? '0 : idx_q + 1'b1;
				end
				BK_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						have_prev_q <= 1'b1;
						found_q     <= 1'b0;
						emit_cnt_q  <= emit_cnt_q + 1'b1;
						idx_q       <= '0;
					end
				end
				default: idx_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ids_q[wr_slot]   <= cmd.id;
			dists_q[wr_slot] <= cmd.dist_val;
		end
		if ((state_q == BK_SCAN) && take) best_q <= cand;
		if (emit) begin
			prev_q    <= best_q;
			valid_res <= (fill_q != '0);
			last      <= emit_last;
			if (fill_q == '0) begin
				nearest_id <= '0;
				distance   <= '0;
			end else begin
				nearest_id <= best_q[SLOT_W +: ID_W];
				distance   <= best_q[SLOT_W + ID_W +: DIST_W];
			end
		end
	end

	`KNN_ASSERT(a_fill_bound, clk, arst_n, (fill_q <= CNT_W'(LIST_SIZE)), "fill count past list size")
	`KNN_ASSERT(a_emit_found, clk, arst_n, ((state_q == BK_EMIT) && (fill_q != '0)) |-> found_q, "emit without a selected entry")
	`KNN_ASSERT(a_worst_full, clk, arst_n, (state_q == BK_WORST) |-> full, "worst rescan on a list that is not full")
	`KNN_ASSERT_NEVER(a_pop_busy, clk, arst_n, pop && (state_q != BK_IDLE), "command taken while busy")

endmodule

@@ sv/knn_top_k_list.sv @@
`timescale 1ns / 1ps
// path: a finished point goes from the front register through the command FIFO into the list
// throughput: one item per cycle in; clear, read and last items wait while the queue is full
// list side: an insert writes one slot, then a worst-entry rescan over all slots once full
// readout: each entry is picked by a selection scan over one read port, then emitted
// reset: arst_n clears all control state at once; list contents undefined, no clearing pass
// ----------------------------------------------------------------------------
// knn_top_k_list
// brute force k nearest neighbor list with sorted readout
// ----------------------------------------------------------------------------
module knn_top_k_list
	import knn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // point_id, data_coord, query_coord
	input  logic [1:0]  s_axis_tuser,   // kind
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // nearest_id, distance
	output logic        m_axis_tuser,   // valid_res
	output logic        m_axis_tlast
);

	q_stat_t            q_stat;
	logic               push;
	logic               pop;
	cmd_t               push_cmd;
	cmd_t               head_cmd;
	logic [ID_W-1:0]    nearest_id;
	logic [DIST_W-1:0]  distance;

	knn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.kind          (s_axis_tuser),
		.point_id      (s_axis_tdata[23:0]),
		.data_coord    (s_axis_tdata[39:24]),
		.query_coord   (s_axis_tdata[55:40]),
		.last_coord    (s_axis_tlast),
		.q_stat        (q_stat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	knn_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	knn_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (head_cmd),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.nearest_id    (nearest_id),
		.distance      (distance),
		.valid_res     (m_axis_tuser),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = {distance, nearest_id};

endmodule

@@ test/knn_top_k_list_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_top_k_list_test
// streams clear, coordinate and readout items into the neighbor list, tracks
// the kept points in a local copy and checks every sorted readout item field
// by field; runs through idle and stall phases and one long output hold-off
// ----------------------------------------------------------------------------
module knn_top_k_list_test;
	import knn_pkg::*;

	localparam logic [1:0]        KIND_UNUSED = 2'd3;
	localparam logic [DIST_W-1:0] DIST_SAT    = {DIST_W{1'b1}};
	localparam int                HOLD_CYCLES = 400;
	localparam int                STALL_LIMIT = 5000;
	localparam int                DRAIN_WAIT  = 300;
	localparam int                LONG_COORDS = 4;

	typedef struct packed {
		logic [1:0]                kind;
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] dcoord;
		logic signed [COORD_W-1:0] qcoord;
		logic                      last;
	} stream_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] dist_val;
		logic              valid;
		logic              last;
	} neighbor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;   // point_id, data_coord, query_coord
	logic [1:0]  s_axis_tuser = '0;   // kind
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // nearest_id, distance
	logic        m_axis_tuser;        // valid_res
	logic        m_axis_tlast;

	stream_item_t pending_items[$];
	stream_item_t cur_item;
	neighbor_t    expected_neighbors[$];

	logic [ID_W-1:0]   nn_ids[LIST_SIZE];
	logic [DIST_W-1:0] nn_dists[LIST_SIZE];
	int                nn_fill = 0;
	logic [DIST_W-1:0] nn_worst_dist = '0;
	int                nn_worst_slot = 0;
	logic [DIST_W-1:0] nn_accum = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	knn_top_k_list DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		error_count++;
	endtask

	task automatic add_pending(input stream_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_expected(input neighbor_t res);
		expected_neighbors.insert(expected_neighbors.size(), res);
	endtask

	task automatic rescan_worst();
		nn_worst_dist = nn_dists[0];
		nn_worst_slot = 0;
		for (int i = 1; i < LIST_SIZE; i++) begin
			if (nn_dists[i] > nn_worst_dist) begin
				nn_worst_dist = nn_dists[i];
				nn_worst_slot = i;
			end
		end
	endtask

	// update the local neighbor list and queue the readout it causes
	task automatic track_item(input stream_item_t it);
		longint            diff;
		logic [63:0]       sum;
		logic [ID_W-1:0]   ids[LIST_SIZE];
		logic [DIST_W-1:0] ds[LIST_SIZE];
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] d;
		neighbor_t         res;
		int                j;
		case (it.kind)
			KIND_CLEAR: begin
				nn_fill = 0;
				nn_accum = '0;
			end
			KIND_COORD: begin
				diff = longint'($signed(it.dcoord)) - longint'($signed(it.qcoord));
				sum = {16'd0, nn_accum} + 64'(diff * diff);
				if (sum > {16'd0, DIST_SAT})
					sum = {16'd0, DIST_SAT};
				if (it.last) begin
					if (nn_fill < LIST_SIZE) begin
						nn_ids[nn_fill] = it.id;
						nn_dists[nn_fill] = sum[DIST_W-1:0];
						nn_fill++;
						if (nn_fill == LIST_SIZE)
							rescan_worst();
					end else if (sum[DIST_W-1:0] < nn_worst_dist) begin
						nn_ids[nn_worst_slot] = it.id;
						nn_dists[nn_worst_slot] = sum[DIST_W-1:0];
						rescan_worst();
					end
					nn_accum = '0;
				end else begin
					nn_accum = sum[DIST_W-1:0];
				end
			end
			KIND_READ: begin
				if (nn_fill == 0) begin
					res = '{id: '0, dist_val: '0, valid: 1'b0, last: 1'b1};
					add_expected(res);
				end else begin
					for (int i = 0; i < nn_fill; i++) begin
						d = nn_dists[i];
						id = nn_ids[i];
						j = i;
						while (j > 0 && (d < ds[j-1] || (d == ds[j-1] && id < ids[j-1]))) begin
							ds[j] = ds[j-1];
							ids[j] = ids[j-1];
							j--;
						end
						ds[j] = d;
						ids[j] = id;
					end
					for (int i = 0; i < nn_fill; i++) begin
						res = '{id: ids[i], dist_val: ds[i], valid: 1'b1,
							last: (i == nn_fill - 1)};
						add_expected(res);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic stream_item_t make_item(input logic [1:0] kind, input logic [ID_W-1:0] id,
			input logic [COORD_W-1:0] dc, input logic [COORD_W-1:0] qc, input logic last);
		make_item = '{kind: kind, id: id, dcoord: dc, qcoord: qc, last: last};
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input bit narrow);
		if (narrow)
			pick_coord = COORD_W'($signed($urandom_range(6)) - 3);
		else
			pick_coord = COORD_W'($urandom);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(3) == 0)
			pick_id = ID_W'($urandom_range(15));
		else
			pick_id = ID_W'($urandom);
	endfunction

	// a point of dims coordinates; only the label on its last item counts
	task automatic queue_point(input int dims, input bit narrow);
		for (int i = 0; i < dims; i++)
			add_pending(make_item(KIND_COORD, pick_id(), pick_coord(narrow),
				pick_coord(narrow), i == dims - 1));
	endtask

	task automatic queue_random(input int target);
		int count;
		int r;
		int dims;
		count = 0;
		while (count < target) begin
			r = $urandom_range(99);
			if (r < 6) begin
				add_pending(make_item(KIND_UNUSED, ID_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), 1'($urandom)));
			end else if (r < 9) begin
				add_pending(make_item(KIND_CLEAR, ID_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), 1'($urandom)));
				count++;
			end else if (r < 20) begin
				add_pending(make_item(KIND_READ, ID_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), 1'($urandom)));
				count++;
			end else if (r < 25) begin
				// point cut short by a clear or with a readout in the middle
				dims = $urandom_range(1, 3);
				for (int i = 0; i < dims; i++)
					add_pending(make_item(KIND_COORD, pick_id(), pick_coord(1'b0),
						pick_coord(1'b0), 1'b0));
				add_pending(make_item($urandom_range(1) ? KIND_CLEAR : KIND_READ,
					ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'($urandom)));
				count += dims + 1;
			end else begin
				dims = $urandom_range(1, 4);
				queue_point(dims, $urandom_range(1));
				count += dims;
			end
		end
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
	endtask

	task automatic queue_directed();
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		add_pending(make_item(KIND_COORD, 24'hFFFFFF, 16'h8000, 16'h7FFF, 1'b1));
		add_pending(make_item(KIND_COORD, 24'h000000, 16'h7FFF, 16'h8000, 1'b0));
		add_pending(make_item(KIND_COORD, 24'h000001, 16'h7FFF, 16'h8000, 1'b1));
		add_pending(make_item(KIND_COORD, 24'h000005, 16'h0000, 16'h0000, 1'b1));
		add_pending(make_item(KIND_COORD, 24'h000003, 16'd100, 16'd100, 1'b1));
		add_pending(make_item(KIND_COORD, 24'h000007, 16'hFFFF, 16'h0001, 1'b0));
		add_pending(make_item(KIND_COORD, 24'h000007, 16'h0001, 16'hFFFF, 1'b1));
		add_pending(make_item(KIND_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		add_pending(make_item(KIND_READ, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		add_pending(make_item(KIND_CLEAR, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		// clear in the middle of a point drops the partial sum
		add_pending(make_item(KIND_COORD, 24'h000009, 16'd5, 16'd0, 1'b0));
		add_pending(make_item(KIND_CLEAR, '0, '0, '0, 1'b0));
		add_pending(make_item(KIND_COORD, 24'h000009, 16'd2, 16'd0, 1'b1));
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		// long point at the coordinate extremes
		for (int i = 0; i < LONG_COORDS; i++)
			add_pending(make_item(KIND_COORD, 24'hABCDEF, 16'h8000, 16'h7FFF,
				i == LONG_COORDS - 1));
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_neighbors.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				track_item(cur_item);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_item = pending_items.pop_front();
					s_axis_tdata <= {cur_item.qcoord, cur_item.dcoord, cur_item.id};
					s_axis_tuser <= cur_item.kind;
					s_axis_tlast <= cur_item.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		neighbor_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_neighbors.size() == 0) begin
					report_mismatch($sformatf("unexpected item id %0h dist %0h",
						m_axis_tdata[23:0], m_axis_tdata[71:24]));
				end else begin
					want = expected_neighbors.pop_front();
					if (m_axis_tdata[23:0] !== want.id)
						report_mismatch($sformatf("nearest_id %0h, expected %0h",
							m_axis_tdata[23:0], want.id));
					if (m_axis_tdata[71:24] !== want.dist_val)
						report_mismatch($sformatf("distance %0h, expected %0h",
							m_axis_tdata[71:24], want.dist_val));
					if (m_axis_tuser !== want.valid)
						report_mismatch($sformatf("valid_res %0b, expected %0b",
							m_axis_tuser, want.valid));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							m_axis_tlast, want.last));
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		stall_pct = 0;
		queue_directed();
		wait_idle();

		idle_pct = 70;
		stall_pct = 0;
		queue_random(50);
		wait_idle();

		idle_pct = 0;
		stall_pct = 70;
		queue_random(50);
		wait_idle();

		idle_pct = 10;
		stall_pct = 10;
		queue_random(50);
		wait_idle();

		// output held off while the input keeps coming
		idle_pct = 0;
		stall_pct = 0;
		hold_req++;
		add_pending(make_item(KIND_CLEAR, '0, '0, '0, 1'b0));
		for (int i = 0; i < LIST_SIZE; i++)
			queue_point(1, 1'b1);
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		for (int i = 0; i < 4; i++)
			queue_point(1, 1'b1);
		repeat (3)
			add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		for (int i = 0; i < 3; i++)
			queue_point(2, 1'b0);
		add_pending(make_item(KIND_READ, '0, '0, '0, 1'b0));
		wait_idle();

		idle_pct = 0;
		stall_pct = 0;
		queue_random(50);
		wait_idle();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ knn_top_k_list.f @@
+incdir+sv
sv/knn_pkg.sv
sv/knn_cmd_fifo.sv
sv/knn_front.sv
sv/knn_back.sv
sv/knn_top_k_list.sv
test/knn_top_k_list_test.sv
